// File: design/glob_wildcard_matcher_top_macros.svh
// Assertion helpers used by the matcher RTL (gwm_nfa).
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef GLOB_WILDCARD_MATCHER_TOP_MACROS_SVH
`define GLOB_WILDCARD_MATCHER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GWM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glob matcher check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GWM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glob matcher check failed");

`endif

// File: design/gwm_pkg.sv
package gwm_pkg;

	localparam int PATTERN_MAX = 32;
	localparam int ACT_W       = PATTERN_MAX + 1;
	localparam int LEN_W       = 6;
	localparam int SCAN_LEVELS = $clog2(ACT_W);
	localparam int WORD_W      = 64;
	localparam int NUM_WORDS   = 4;
	localparam int CFG_IDX_W   = 3;

	localparam logic [7:0] STAR_CODE     = 8'h2A;
	localparam logic [7:0] QUESTION_CODE = 8'h3F;
	localparam logic [7:0] UPPER_FIRST   = 8'h41;
	localparam logic [7:0] UPPER_LAST    = 8'h5A;
	localparam logic [7:0] CASE_OFFSET   = 8'h20;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_A  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_B  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_C  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_D  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ICASE  = 3'd5;

	typedef logic [ACT_W-1:0] act_t;

	typedef struct packed {
		logic [PATTERN_MAX-1:0][7:0] pat_bytes;
		logic [PATTERN_MAX-1:0]      star;
		logic [PATTERN_MAX-1:0]      qmark;
		logic [PATTERN_MAX-1:0]      in_use;
		logic [LEN_W-1:0]            len;
		logic                        icase;
		act_t                        start_set;
		logic                        restart;
	} gwm_cfg_t;

	function automatic logic [7:0] fold_byte(logic [7:0] b, logic icase);
		logic [7:0] r;
		r = b;
		if (icase && b >= UPPER_FIRST && b <= UPPER_LAST) begin
			r = b + CASE_OFFSET;
		end
		return r;
	endfunction

	// Prefix scan: a set position spreads forward across a run of stars.
	// Equivalent to a carry chain with generate = set bits and
	// propagate = star at the position just below.
	function automatic act_t star_closure(act_t gen, logic [PATTERN_MAX-1:0] star);
		act_t g;
		act_t p;
		act_t g_n;
		act_t p_n;
		int   d;
		g = gen;
		p = {star, 1'b0};
		for (int lvl = 0; lvl < SCAN_LEVELS; lvl++) begin
			d = 1 << lvl;
			for (int k = 0; k < ACT_W; k++) begin
				if (k >= d) begin
					g_n[k] = g[k] | (p[k] & g[k-d]);
					p_n[k] = p[k] & p[k-d];
				end else begin
					g_n[k] = g[k];
					p_n[k] = 1'b0;
				end
			end
			g = g_n;
			p = p_n;
		end
		return g;
	endfunction

endpackage

// File: design/glob_wildcard_matcher_top.sv
// Glob matcher: checks a byte stream against a pattern of up to 32 bytes in
// which '*' matches any run of bytes and '?' matches any single byte.
// Input channel (in_valid/in_ready): one transfer per string byte, with
// no_char for an item without a byte and last_char on the final item.
// Output channel (out_valid/out_ready): one transfer carrying matched for
// each item that had last_char set; other items produce nothing.
// Configuration is a plain write port (cfg_wr_en, cfg_addr, cfg_wr_data);
// any write to a known register restarts the string in progress.
// Throughput is one input transfer per cycle unless a final item waits on a
// blocked result register. The result of a final item goes first into the
// input register, then through the position-vector update into the result
// register. The update is a single pass of compare logic plus a six-level
// prefix scan for runs of stars.
// Reset clears the pattern, the length and the case mode, empties both
// registers and restarts at the start position set.
// When the receiver stalls, the result register holds; further bytes of
// the next string keep flowing, and only a second final item waits.
module glob_wildcard_matcher_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [gwm_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [gwm_pkg::WORD_W-1:0]     cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     char_code,
	input  logic                           no_char,
	input  logic                           last_char,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           matched
);

	// Folded pattern, wildcard masks and the start set, all derived from the
	// configuration registers.
	gwm_pkg::gwm_cfg_t cfg;

	gwm_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_addr    (cfg_addr),
		.cfg_wr_data (cfg_wr_data),
		.cfg         (cfg)
	);

	// Input register, position-vector state and the result register.
	gwm_nfa u_nfa (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.no_char   (no_char),
		.last_char (last_char),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.matched   (matched)
	);

endmodule

// File: design/gwm_cfg.sv
module gwm_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [gwm_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [gwm_pkg::WORD_W-1:0]          cfg_wr_data,
	output gwm_pkg::gwm_cfg_t                   cfg
);

	logic [gwm_pkg::NUM_WORDS-1:0][gwm_pkg::WORD_W-1:0] pat_words_q;
	logic [gwm_pkg::LEN_W-1:0]                          len_q;
	logic                                               icase_q;
	logic [gwm_pkg::PATTERN_MAX-1:0][7:0]               raw_bytes;
	logic [gwm_pkg::LEN_W-1:0]                          len_used;
	logic                                               known_reg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_words_q <= '0;
			len_q       <= '0;
			icase_q     <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				gwm_pkg::REG_PAT_A:  pat_words_q[0] <= cfg_wr_data;
				gwm_pkg::REG_PAT_B:  pat_words_q[1] <= cfg_wr_data;
				gwm_pkg::REG_PAT_C:  pat_words_q[2] <= cfg_wr_data;
				gwm_pkg::REG_PAT_D:  pat_words_q[3] <= cfg_wr_data;
				gwm_pkg::REG_LENGTH: len_q <= cfg_wr_data[gwm_pkg::LEN_W-1:0];
				gwm_pkg::REG_ICASE:  icase_q <= cfg_wr_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_addr)
			gwm_pkg::REG_PAT_A, gwm_pkg::REG_PAT_B, gwm_pkg::REG_PAT_C,
			gwm_pkg::REG_PAT_D, gwm_pkg::REG_LENGTH, gwm_pkg::REG_ICASE: known_reg = 1'b1;
			default: known_reg = 1'b0;
		endcase
	end

	assign raw_bytes = pat_words_q;
	assign len_used  = (len_q > gwm_pkg::LEN_W'(gwm_pkg::PATTERN_MAX)) ?
		gwm_pkg::LEN_W'(gwm_pkg::PATTERN_MAX) : len_q;

	always_comb begin
		for (int i = 0; i < gwm_pkg::PATTERN_MAX; i++) begin
			cfg.pat_bytes[i] = gwm_pkg::fold_byte(raw_bytes[i], icase_q);
			cfg.in_use[i]    = gwm_pkg::LEN_W'(i) < len_used;
			cfg.star[i]      = cfg.in_use[i] && (cfg.pat_bytes[i] == gwm_pkg::STAR_CODE);
			cfg.qmark[i]     = cfg.in_use[i] && (cfg.pat_bytes[i] == gwm_pkg::QUESTION_CODE);
		end
		cfg.len       = len_used;
		cfg.icase     = icase_q;
		cfg.start_set = gwm_pkg::star_closure(gwm_pkg::act_t'(1), cfg.star);
		cfg.restart   = cfg_wr_en && known_reg;
	end

endmodule

// File: design/gwm_nfa.sv
`include "glob_wildcard_matcher_top_macros.svh"

module gwm_nfa (
	input  logic              clk,
	input  logic              arst_n,
	input  gwm_pkg::gwm_cfg_t cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        char_code,
	input  logic              no_char,
	input  logic              last_char,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              matched
);

	logic                          valid_s1;
	logic [7:0]                    char_s1;
	logic                          none_s1;
	logic                          last_s1;
	gwm_pkg::act_t                 active_q;
	logic                          fresh_q;
	logic                          out_valid_q;
	logic                          matched_q;
	logic                          advance;
	logic [7:0]                    ch;
	gwm_pkg::act_t                 cur;
	gwm_pkg::act_t                 stepped;
	gwm_pkg::act_t                 next_set;
	logic [gwm_pkg::PATTERN_MAX-1:0] lit_ok;
	logic                          hit;

	// The stage moves on unless it holds a final item and the result slot is blocked.
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			none_s1 <= no_char;
			last_s1 <= last_char;
		end
	end

	always_comb begin
		cur = fresh_q ? cfg.start_set : active_q;
		ch  = gwm_pkg::fold_byte(char_s1, cfg.icase);
		stepped = '0;
		for (int i = 0; i < gwm_pkg::PATTERN_MAX; i++) begin
			lit_ok[i] = cfg.in_use[i] && !cfg.star[i] &&
				(cfg.qmark[i] || (cfg.pat_bytes[i] == ch));
			stepped[i]   = stepped[i] | (cur[i] & cfg.star[i]);
			stepped[i+1] = cur[i] & lit_ok[i];
		end
		next_set = none_s1 ? cur : gwm_pkg::star_closure(stepped, cfg.star);
		hit      = next_set[cfg.len];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b1;
		end else if (cfg.restart || (advance && last_s1)) begin
			fresh_q <= 1'b1;
		end else if (advance) begin
			fresh_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !last_s1) begin
			active_q <= next_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			matched_q <= hit;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;

	`GWM_ASSERT_NEXT(a_last_restarts, advance && last_s1, fresh_q && out_valid_q)
	`GWM_ASSERT_NEXT(a_mid_keeps_state, advance && !last_s1 && !cfg.restart, !fresh_q)
	`GWM_ASSERT_SAME(a_state_in_range, !fresh_q,
		(active_q & ~{cfg.in_use, 1'b1}) == '0)
	`GWM_ASSERT_SAME(a_stall_cause, !in_ready,
		valid_s1 && last_s1 && out_valid_q && !out_ready)

endmodule

// File: dv/glob_wildcard_matcher_top_test.sv
`timescale 1ns / 100ps

module glob_wildcard_matcher_top_test;
	import gwm_pkg::*;

	// Register indexes past the last real register. Writes to them must leave
	// the pattern and the position set alone.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Length of the quiet wait that a pause holds once no verdict is owed and no
	// byte is on the input, before the plan moves on, as before a register write.
	localparam int unsigned QUIET_CYCLES = 4;
	localparam int unsigned MAX_IDLE     = 17;
	localparam int unsigned PHASE_BYTES  = 56;

	typedef enum logic [1:0] {STEP_BYTE, STEP_WRITE, STEP_SETTLE} step_kind_e;

	// One entry of the stimulus plan: a string byte, a register write, or a
	// pause that lasts until every verdict has arrived.
	typedef struct packed {
		step_kind_e            kind;
		logic [7:0]            code;
		logic                  none;
		logic                  last;
		logic [CFG_IDX_W-1:0]  addr;
		logic [WORD_W-1:0]     data;
		logic [4:0]            gap;
		logic                  calm;
	} step_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_wr_en   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr    = '0;
	logic [WORD_W-1:0]     cfg_wr_data = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [7:0]            char_code   = '0;
	logic                  no_char     = 1'b0;
	logic                  last_char   = 1'b0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic                  matched;

	glob_wildcard_matcher_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_addr    (cfg_addr),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.no_char     (no_char),
		.last_char   (last_char),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.matched     (matched)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Plan of pending stimulus, and the verdicts that the block still owes.
	step_t       pending[$];
	logic        verdicts_due[$];

	// Our own copy of the block's registers and of its live position set.
	logic [WORD_W-1:0] m_words[NUM_WORDS];
	logic [LEN_W-1:0]  m_len;
	logic              m_icase;
	act_t              m_live;

	// Generator view of the pattern, used to load the pattern and to build matching strings.
	logic [7:0]   gen_pb[PATTERN_MAX];
	int unsigned  gen_len;
	bit           gen_icase;
	bit           calm_now;
	logic [7:0]   word_buf[$];

	int unsigned  planned_bytes;
	int unsigned  settings_made;
	int unsigned  bytes_taken;
	int unsigned  verdicts_seen;
	int unsigned  verdict_hits;
	int unsigned  errors;

	// ---------------------------------------------------------------------
	// Position-set predictor.
	// ---------------------------------------------------------------------

	// A pattern length above the vector size behaves as the full size.
	function automatic int unsigned live_len();
		if (m_len > PATTERN_MAX) begin
			return PATTERN_MAX;
		end
		return int'(m_len);
	endfunction

	function automatic logic [7:0] fold_case(logic [7:0] b);
		if (m_icase && b >= UPPER_FIRST && b <= UPPER_LAST) begin
			return b + CASE_OFFSET;
		end
		return b;
	endfunction

	function automatic logic [7:0] pattern_at(int unsigned i);
		return fold_case(m_words[i / 8][(i % 8) * 8 +: 8]);
	endfunction

	// A reachable star also makes the position behind it reachable, so the
	// walk runs upward and carries across a run of stars.
	function automatic act_t close_stars(act_t s);
		for (int unsigned i = 0; i < live_len(); i++) begin
			if (s[i] && pattern_at(i) == STAR_CODE) begin
				s[i + 1] = 1'b1;
			end
		end
		return s;
	endfunction

	// Advances the live set by one accepted byte and, on the final byte of a
	// string, queues the verdict and returns to the start set.
	task automatic take_byte(input logic [7:0] code, input logic none, input logic last);
		act_t         nxt;
		logic [7:0]   c;
		logic [7:0]   p;
		int unsigned  n;
		n = live_len();
		if (!none) begin
			c = fold_case(code);
			nxt = '0;
			for (int unsigned i = 0; i < n; i++) begin
				if (m_live[i]) begin
					p = pattern_at(i);
					if (p == STAR_CODE) begin
						nxt[i] = 1'b1;
					end else if (p == QUESTION_CODE || p == c) begin
						nxt[i + 1] = 1'b1;
					end
				end
			end
			m_live = close_stars(nxt);
		end
		if (last) begin
			verdicts_due.push_back(m_live[n]);
			m_live = close_stars(act_t'(1));
		end
	endtask

	// Any write to a known register restarts the string; unknown indexes do
	// nothing at all.
	task automatic apply_write(input logic [CFG_IDX_W-1:0] addr, input logic [WORD_W-1:0] data);
		case (addr)
			REG_PAT_A: m_words[0] = data;
			REG_PAT_B: m_words[1] = data;
			REG_PAT_C: m_words[2] = data;
			REG_PAT_D: m_words[3] = data;
			REG_LENGTH: m_len = data[LEN_W-1:0];
			REG_ICASE: m_icase = data[0];
			default: return;
		endcase
		m_live = close_stars(act_t'(1));
	endtask

	// ---------------------------------------------------------------------
	// Stimulus planning.
	// ---------------------------------------------------------------------

	function automatic logic [4:0] draw_idle();
		if (calm_now) begin
			return '0;
		end
		return 5'($urandom_range(0, MAX_IDLE));
	endfunction

	task automatic push_byte(input logic [7:0] code, input logic none, input logic last);
		step_t s;
		s = '0;
		s.kind = STEP_BYTE;
		s.code = code;
		s.none = none;
		s.last = last;
		s.gap = draw_idle();
		s.calm = calm_now;
		pending.push_back(s);
		planned_bytes++;
	endtask

	task automatic push_write(input logic [CFG_IDX_W-1:0] addr, input logic [WORD_W-1:0] data);
		step_t s;
		s = '0;
		s.kind = STEP_WRITE;
		s.addr = addr;
		s.data = data;
		pending.push_back(s);
	endtask

	task automatic push_settle();
		step_t s;
		s = '0;
		s.kind = STEP_SETTLE;
		pending.push_back(s);
	endtask

	function automatic logic [WORD_W-1:0] pack_word(int unsigned w);
		logic [WORD_W-1:0] r;
		for (int unsigned k = 0; k < 8; k++) begin
			r[k * 8 +: 8] = gen_pb[w * 8 + k];
		end
		return r;
	endfunction

	// Loads gen_pb as the new pattern once the block has gone quiet. The
	// length and case registers get random upper bits, which must be ignored.
	task automatic new_setting(input int unsigned len, input bit icase);
		logic [WORD_W-1:0] d;
		push_settle();
		push_write(REG_PAT_A, pack_word(0));
		push_write(REG_PAT_B, pack_word(1));
		push_write(REG_PAT_C, pack_word(2));
		push_write(REG_PAT_D, pack_word(3));
		d = {$urandom, $urandom};
		d[LEN_W-1:0] = len[LEN_W-1:0];
		push_write(REG_LENGTH, d);
		d = {$urandom, $urandom};
		d[0] = icase;
		push_write(REG_ICASE, d);
		push_write(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom, $urandom});
		gen_len = len;
		gen_icase = icase;
		settings_made++;
	endtask

	function automatic logic [7:0] any_letter();
		case ($urandom_range(0, 4))
			0: return "a";
			1: return "b";
			2: return "c";
			3: return "A";
			default: return "B";
		endcase
	endfunction

	// Bytes used under a star and in noise: mostly letters so that strings
	// stay close to the pattern, sometimes any byte at all.
	function automatic logic [7:0] filler_byte();
		if ($urandom_range(0, 4) == 0) begin
			return 8'($urandom_range(0, 255));
		end
		return any_letter();
	endfunction

	function automatic logic [7:0] pattern_pick();
		case ($urandom_range(0, 9))
			0, 1: return STAR_CODE;
			2: return QUESTION_CODE;
			3: return 8'($urandom_range(0, 255));
			default: return any_letter();
		endcase
	endfunction

	// Fills word_buf with a string that the current pattern accepts.
	task automatic build_match();
		logic [7:0]   b;
		int unsigned  n;
		word_buf.delete();
		n = (gen_len > PATTERN_MAX) ? PATTERN_MAX : gen_len;
		for (int unsigned i = 0; i < n; i++) begin
			b = gen_pb[i];
			if (gen_icase && b >= UPPER_FIRST && b <= UPPER_LAST) begin
				b = b + CASE_OFFSET;
			end
			if (b == STAR_CODE) begin
				repeat ($urandom_range(0, 3)) word_buf.push_back(filler_byte());
			end else if (b == QUESTION_CODE) begin
				word_buf.push_back(8'($urandom_range(0, 255)));
			end else begin
				// With case folding on, a letter may come in either case.
				if (gen_icase && b >= "a" && b <= "z" && $urandom_range(0, 1) != 0) begin
					b = b - CASE_OFFSET;
				end
				word_buf.push_back(b);
			end
		end
	endtask

	// Breaks a string by changing, dropping or adding one byte.
	task automatic spoil_string();
		int unsigned at;
		if (word_buf.size() == 0) begin
			word_buf.push_back(filler_byte());
			return;
		end
		at = $urandom_range(0, word_buf.size() - 1);
		case ($urandom_range(0, 2))
			0: word_buf[at] = filler_byte();
			1: word_buf.delete(at);
			default: word_buf.insert(at, filler_byte());
		endcase
	endtask

	// Plans word_buf as one string. Items without a byte are sprinkled in,
	// and sometimes one of them closes the string.
	task automatic send_string();
		bit tail_none;
		if (word_buf.size() == 0) begin
			push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
			return;
		end
		tail_none = ($urandom_range(0, 7) == 0);
		for (int unsigned k = 0; k < word_buf.size(); k++) begin
			if ($urandom_range(0, 9) == 0) begin
				push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
			end
			push_byte(word_buf[k], 1'b0, !tail_none && k == word_buf.size() - 1);
		end
		if (tail_none) begin
			push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		end
	endtask

	// ---------------------------------------------------------------------
	// Driver: feeds the plan into the input channel and the write port.
	// Each byte waits its drawn number of idle cycles before valid rises;
	// valid then holds with a steady payload until the transfer happens.
	// Every signal gets at most one nonblocking update per edge.
	// ---------------------------------------------------------------------

	step_t        front_step;
	logic         valid_next;
	logic         wr_next;
	bit           armed;
	int unsigned  hold_count;
	logic         rx_calm = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			valid_next = in_valid;
			wr_next = 1'b0;
			if (in_valid && in_ready) begin
				take_byte(char_code, no_char, last_char);
				bytes_taken++;
				valid_next = 1'b0;
			end
			if (!valid_next && pending.size() != 0) begin
				if (!armed) begin
					armed = 1'b1;
					hold_count = (pending[0].kind == STEP_SETTLE) ? QUIET_CYCLES : pending[0].gap;
				end
				case (pending[0].kind)
					STEP_BYTE: begin
						if (hold_count != 0) begin
							hold_count--;
						end else begin
							front_step = pending.pop_front();
							char_code <= front_step.code;
							no_char <= front_step.none;
							last_char <= front_step.last;
							rx_calm <= front_step.calm;
							valid_next = 1'b1;
							armed = 1'b0;
						end
					end
					STEP_WRITE: begin
						front_step = pending.pop_front();
						cfg_addr <= front_step.addr;
						cfg_wr_data <= front_step.data;
						wr_next = 1'b1;
						apply_write(front_step.addr, front_step.data);
						armed = 1'b0;
					end
					default: begin
						// The pause restarts its quiet count while a verdict is
						// owed or a transfer has just happened.
						if (verdicts_due.size() != 0 || in_valid) begin
							hold_count = QUIET_CYCLES;
						end else if (hold_count != 0) begin
							hold_count--;
						end else begin
							front_step = pending.pop_front();
							armed = 1'b0;
						end
					end
				endcase
			end
			in_valid <= valid_next;
			cfg_wr_en <= wr_next;
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: checks each result transfer against the oldest verdict due,
	// then holds ready low for a drawn number of cycles.
	// ---------------------------------------------------------------------

	logic         ready_next;
	logic         want;
	int unsigned  stall_left;

	always @(posedge clk) begin
		if (arst_n) begin
			ready_next = out_ready;
			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					$display("%0t: result transfer with no verdict due: expected none, got matched=%0b",
						$time, matched);
					errors++;
				end else begin
					want = verdicts_due.pop_front();
					verdicts_seen++;
					if (want) begin
						verdict_hits++;
					end
					if (matched !== want) begin
						$display("%0t: verdict mismatch: expected matched=%0b, got %0b",
							$time, want, matched);
						errors++;
					end
				end
				stall_left = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
				ready_next = (stall_left == 0);
			end else if (!out_ready) begin
				if (stall_left != 0) begin
					stall_left--;
				end
				if (stall_left == 0) begin
					ready_next = 1'b1;
				end
			end
			out_ready <= ready_next;
		end
	end

	// ---------------------------------------------------------------------
	// Plan, reset and end of run.
	// ---------------------------------------------------------------------

	initial begin
		int unsigned  len_pick;
		int unsigned  mark;
		int unsigned  pick;

		for (int unsigned w = 0; w < NUM_WORDS; w++) begin
			m_words[w] = '0;
		end
		m_len = '0;
		m_icase = 1'b0;
		m_live = close_stars(act_t'(1));
		for (int unsigned i = 0; i < PATTERN_MAX; i++) begin
			gen_pb[i] = '0;
		end
		gen_len = 0;
		gen_icase = 1'b0;
		calm_now = 1'b0;

		// Reset pattern is empty: only the empty string matches.
		push_byte(8'hA5, 1'b1, 1'b1);
		push_byte(8'hFF, 1'b0, 1'b1);

		// "A*?" then a zero byte, with case folding. The zero byte is a plain
		// literal, the star may be empty or long, and a string that closes on
		// an item without a byte is judged on the bytes seen so far.
		gen_pb[0] = "A";
		gen_pb[1] = STAR_CODE;
		gen_pb[2] = QUESTION_CODE;
		gen_pb[3] = 8'h00;
		new_setting(4, 1'b1);
		push_byte("a", 1'b0, 1'b0);
		push_byte("x", 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b1);
		push_byte("A", 1'b0, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(8'h7F, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b1);
		push_byte("b", 1'b0, 1'b0);
		push_byte(8'h5A, 1'b1, 1'b1);

		// Thirty-two stars with an oversized length: everything matches.
		for (int unsigned i = 0; i < PATTERN_MAX; i++) begin
			gen_pb[i] = STAR_CODE;
		end
		new_setting(63, 1'b0);
		push_byte("Z", 1'b0, 1'b1);
		push_byte(8'h00, 1'b1, 1'b1);

		// "a?" without case folding: upper case must not match.
		for (int unsigned i = 0; i < PATTERN_MAX; i++) begin
			gen_pb[i] = 8'h00;
		end
		gen_pb[0] = "a";
		gen_pb[1] = QUESTION_CODE;
		new_setting(2, 1'b0);
		push_byte("A", 1'b0, 1'b0);
		push_byte("b", 1'b0, 1'b1);
		push_byte("a", 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b1);

		// Random phases: a full-length pattern, an empty one, an oversized
		// length, then short patterns. One phase draws no idle gaps and no receiver stalls.
		// Most strings are built to match, some are broken, some are noise.
		for (int unsigned ph = 0; ph < 8; ph++) begin
			calm_now = (ph == 3);
			case (ph)
				0: len_pick = PATTERN_MAX;
				1: len_pick = 0;
				2: len_pick = $urandom_range(PATTERN_MAX + 1, 63);
				default: len_pick = $urandom_range(1, 10);
			endcase
			for (int unsigned i = 0; i < PATTERN_MAX; i++) begin
				if (i < len_pick) begin
					gen_pb[i] = pattern_pick();
				end else begin
					gen_pb[i] = (ph % 2 != 0) ? 8'hFF : 8'($urandom_range(0, 255));
				end
			end
			new_setting(len_pick, ph % 2 != 0);
			mark = planned_bytes;
			while (planned_bytes - mark < PHASE_BYTES) begin
				// Now and then the sender holds off until every verdict is in.
				if ($urandom_range(0, 19) == 0) begin
					push_settle();
				end
				pick = $urandom_range(0, 19);
				if (pick < 11) begin
					build_match();
				end else if (pick < 17) begin
					build_match();
					spoil_string();
				end else begin
					word_buf.delete();
					repeat ($urandom_range(0, 6)) word_buf.push_back(filler_byte());
				end
				send_string();
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending.size() != 0 || in_valid || verdicts_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		$display("Covered %0d input transfers and %0d verdicts (%0d matches) over %0d settings.",
			bytes_taken, verdicts_seen, verdict_hits, settings_made);
		if (errors == 0) begin
			$display("glob_wildcard_matcher_top_test OK");
		end else begin
			$display("glob_wildcard_matcher_top_test NOT OK");
		end
		$finish;
	end

	// A hung handshake or a verdict that never comes ends here.
	initial begin
		#5_000_000;
		$display("%0t: timeout with %0d verdicts still due", $time, verdicts_due.size());
		$display("glob_wildcard_matcher_top_test NOT OK");
		$finish;
	end

endmodule

// File: glob_wildcard_matcher_top.f
+incdir+design
design/gwm_pkg.sv
design/gwm_cfg.sv
design/gwm_nfa.sv
design/glob_wildcard_matcher_top.sv
dv/glob_wildcard_matcher_top_test.sv
